// ===== rtl/disjoint_set_union_find_assert.svh =====
// ----------------------------------------------------------------------------
// Disjoint-set engine assertion macros
// Shared property wrappers for the engine's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_SET_UNION_FIND_ASSERT_SVH
`define DISJOINT_SET_UNION_FIND_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsu assertion failed");

// next-cycle implication, disabled during reset
`define DSU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsu assertion failed");

`endif

// ===== rtl/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Types and constants shared by the disjoint-set engine modules.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int ELEM_W = 10;   // element index field width
    localparam int SIZE_W = 11;   // set size width
    localparam int CFG_W  = 11;   // elements_in_use register width
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_FIND    = 7'b0000100,
        ST_COMP    = 7'b0001000,
        ST_LINK_LO = 7'b0010000,
        ST_LINK_HI = 7'b0100000,
        ST_RESP    = 7'b1000000
    } dsu_state_t;

    typedef struct packed {
        logic              bad_index;
        logic [SIZE_W-1:0] group_size;
        logic              merged;
        logic              same_set;
        logic [ELEM_W-1:0] second_root;
        logic [ELEM_W-1:0] first_root;
    } dsu_res_t;

endpackage

// ===== rtl/disjoint_set_union_find.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find engine (union by size, full path compression) on a stream port.
// ----------------------------------------------------------------------------
// Input transactions on s_axis carry two element indices in tdata and the
// action in tuser (0 = query, 1 = unite); each yields one result transaction
// on m_axis. cfg_wr_en/cfg_wr_data set elements_in_use; the user must write
// it only while the block idles, as the block does not enforce this. After
// reset a clearing pass makes every entry a root of size one; s_axis_tready
// stays low until it finishes. One item at a time: the link store is a
// single RAM with one write and one registered read per cycle, and each hop
// of a parent chain costs one read. A merge adds two link writes after the
// walks of both elements, and an out-of-range item skips the walks. A new
// item can be accepted in the cycle after the result is handed to the output
// register. The output register holds a result while m_axis_tready is low;
// the engine still accepts and works the next item, then waits with its
// result until the register frees up.
// ----------------------------------------------------------------------------
module disjoint_set_union_find
    import dsu_pkg::*;
#(
    parameter int MAX_ELEMS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // first_elem[9:0], second_elem[19:10], zero pad
    input  logic [0:0]            s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // first_root[9:0], second_root[19:10],
                                                  // same_set[20], merged[21],
                                                  // group_size[32:22], bad_index[33], zero pad
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data
);

    localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int ENT_W = SIZE_W + IDX_W;

    logic [CFG_W-1:0]      cfg_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  slot_free;
    logic                  res_valid;
    dsu_res_t              res;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;

    assign slot_free = !out_valid_reg || m_axis_tready;

    dsu_ctrl #(
        .MAX_ELEMS (MAX_ELEMS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .action          (s_axis_tuser[0]),
        .first_elem      (s_axis_tdata[ELEM_W-1:0]),
        .second_elem     (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .elements_in_use (cfg_reg),
        .res_valid       (res_valid),
        .slot_free       (slot_free),
        .res             (res),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

    dsu_mem #(
        .DEPTH (MAX_ELEMS),
        .AW    (IDX_W),
        .DW    (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= OUT_DATA_W'(res);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/dsu_mem.sv =====
// ----------------------------------------------------------------------------
// dsu_mem
// Simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dsu_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 21
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/dsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer: clearing pass, root walks with path compression, size-based link.
// ----------------------------------------------------------------------------
`include "disjoint_set_union_find_assert.svh"

module dsu_ctrl
    import dsu_pkg::*;
#(
    parameter int MAX_ELEMS = 1024,
    parameter int IDX_W     = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [ELEM_W-1:0]       first_elem,
    input  logic [ELEM_W-1:0]       second_elem,
    input  logic [CFG_W-1:0]        elements_in_use,
    output logic                    res_valid,
    input  logic                    slot_free,
    output dsu_res_t                res,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output logic [SIZE_W+IDX_W-1:0] wr_data,
    output logic [IDX_W-1:0]        rd_addr,
    input  logic [SIZE_W+IDX_W-1:0] rd_data
);

    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_ELEMS - 1);

    dsu_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;

    logic              act_reg, act_next;
    logic              sel_b_reg, sel_b_next;
    logic              bad_reg, bad_next;
    logic              same_reg, same_next;
    logic              merged_reg, merged_next;
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [IDX_W-1:0]  ra_reg, ra_next;
    logic [IDX_W-1:0]  rb_reg, rb_next;
    logic [SIZE_W-1:0] sa_reg, sa_next;
    logic [SIZE_W-1:0] sb_reg, sb_next;
    logic [SIZE_W-1:0] gsize_reg, gsize_next;

    logic [IDX_W-1:0]  rd_parent;
    logic [SIZE_W-1:0] rd_size;
    logic [IDX_W-1:0]  start_elem;
    logic [31:0]       eff_count;
    logic              bad_in;
    logic              a_smaller;
    logic [IDX_W-1:0]  winner;
    logic [IDX_W-1:0]  loser;
    logic [SIZE_W-1:0] loser_size;

    assign rd_parent  = rd_data[IDX_W-1:0];
    assign rd_size    = rd_data[IDX_W +: SIZE_W];
    assign start_elem = sel_b_reg ? b_reg : a_reg;

    assign eff_count = (32'(elements_in_use) > 32'(MAX_ELEMS)) ? 32'(MAX_ELEMS)
                                                               : 32'(elements_in_use);
    assign bad_in    = (32'(first_elem) >= eff_count) || (32'(second_elem) >= eff_count);

    // equal sizes keep the first root on top
    assign a_smaller  = sa_reg < sb_reg;
    assign winner     = a_smaller ? rb_reg : ra_reg;
    assign loser      = a_smaller ? ra_reg : rb_reg;
    assign loser_size = a_smaller ? sa_reg : sb_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        act_next    = act_reg;
        sel_b_next  = sel_b_reg;
        bad_next    = bad_reg;
        same_next   = same_reg;
        merged_next = merged_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cur_next    = cur_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        gsize_next  = gsize_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = '0;
        rd_addr     = cur_reg;
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = {SIZE_W'(1), clr_reg};
                if (clr_reg == LastIdx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    a_next      = IDX_W'(first_elem);
                    b_next      = IDX_W'(second_elem);
                    bad_next    = bad_in;
                    same_next   = 1'b0;
                    merged_next = 1'b0;
                    sel_b_next  = 1'b0;
                    rd_addr     = IDX_W'(first_elem);
                    cur_next    = IDX_W'(first_elem);
                    state_next  = bad_in ? ST_RESP : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_next = cur_reg;
                    if (sel_b_reg)
                    begin
                        sb_next = rd_size;
                    end
                    else
                    begin
                        sa_next = rd_size;
                    end
                    // second walk from the start relinks the path
                    rd_addr    = start_elem;
                    cur_next   = start_elem;
                    state_next = ST_COMP;
                end
                else
                begin
                    rd_addr  = rd_parent;
                    cur_next = rd_parent;
                end
            end
            ST_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!sel_b_reg)
                    begin
                        ra_next    = root_reg;
                        sel_b_next = 1'b1;
                        rd_addr    = b_reg;
                        cur_next   = b_reg;
                        state_next = ST_FIND;
                    end
                    else
                    begin
                        rb_next    = root_reg;
                        same_next  = (ra_reg == root_reg);
                        gsize_next = sa_reg;
                        state_next = (act_reg && (ra_reg != root_reg)) ? ST_LINK_LO : ST_RESP;
                    end
                end
                else
                begin
                    // write current node, read its old parent: never the same entry
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = {rd_size, root_reg};
                    rd_addr  = rd_parent;
                    cur_next = rd_parent;
                end
            end
            ST_LINK_LO:
            begin
                wr_en       = 1'b1;
                wr_addr     = loser;
                wr_data     = {loser_size, winner};
                rd_addr     = winner;
                cur_next    = loser;
                ra_next     = winner;
                gsize_next  = sa_reg + sb_reg;
                merged_next = 1'b1;
                state_next  = ST_LINK_HI;
            end
            ST_LINK_HI:
            begin
                wr_en      = 1'b1;
                wr_addr    = ra_reg;
                wr_data    = {gsize_reg, ra_reg};
                rd_addr    = cur_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        if (bad_reg)
        begin
            res.bad_index = 1'b1;
        end
        else
        begin
            res.first_root  = ELEM_W'(ra_reg);
            res.second_root = ELEM_W'(rb_reg);
            res.same_set    = same_reg;
            res.merged      = merged_reg;
            res.group_size  = gsize_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        sel_b_reg  <= sel_b_next;
        bad_reg    <= bad_next;
        same_reg   <= same_next;
        merged_reg <= merged_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        gsize_reg  <= gsize_next;
    end

    `DSU_ASSERT_IMP(a_no_rw_collision, clk, rst_n, wr_en && (state_reg != ST_CLEAR), wr_addr != rd_addr)
    `DSU_ASSERT_IMP(a_res_has_slot, clk, rst_n, res_valid, slot_free)
    `DSU_ASSERT_IMP(a_merge_distinct, clk, rst_n, res_valid && res.merged, !res.same_set && (res.group_size >= SIZE_W'(2)))
    `DSU_ASSERT_IMP(a_bad_is_empty, clk, rst_n, res_valid && res.bad_index, (res.group_size == '0) && !res.merged)
    `DSU_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != ST_IDLE)

endmodule
